[rtl/core/cdc_pkg.sv]
// package for the copy descriptor coalescer
// shared widths, depth and payload structs; no dependencies
`timescale 1ns / 1ps
package cdc_pkg;
   localparam int MaxBlocks  = 64;
   localparam int OffsetBits = 48;
   localparam int LenBits    = OffsetBits + 6;
   localparam int IdxBits    = $clog2(MaxBlocks);
   localparam int CntBits    = $clog2(MaxBlocks + 1);
   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [OffsetBits-1:0] src_addr;
      logic [OffsetBits-1:0] dst_addr;
      logic [OffsetBits-1:0] length;
      logic                  last_block;
   } req_type;

   typedef struct packed {
      logic [OffsetBits-1:0] out_src;
      logic [OffsetBits-1:0] out_dst;
      logic [LenBits-1:0]    out_length;
      logic [LenBits-1:0]    min_run;
      logic [LenBits-1:0]    max_run;
      logic [LenBits-1:0]    total_bytes;
      logic [CntBits-1:0]    run_count;
      logic                  final_entry;
   } rsp_type;

   // classified descriptor handed from front to back
   typedef struct packed {
      logic                  store;
      logic                  last;
      logic [OffsetBits-1:0] src;
      logic [OffsetBits-1:0] dst;
      logic [OffsetBits-1:0] len;
   } cmd_type;
endpackage

[rtl/core/cdc_front.sv]
// front end: accepts descriptors, tracks fill count and marks drops
// depends on cdc_pkg
`timescale 1ns / 1ps
module cdc_front import cdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);
   logic [CntBits-1:0] count_ff, count_in;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   always_comb begin
      cmd_data.store = (count_ff < CntBits'(MaxBlocks));
      cmd_data.last  = req_data.last_block;
      cmd_data.src   = req_data.src_addr;
      cmd_data.dst   = req_data.dst_addr;
      cmd_data.len   = req_data.length;
   end

   // count of descriptors held in the current batch
   always_comb begin
      count_in = count_ff;
      if (req_valid && cmd_ready) begin
         if (req_data.last_block) count_in = '0;
         else if (cmd_data.store) count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end
endmodule

[rtl/core/cdc_queue.sv]
// short fifo between front and back
// depends on cdc_pkg
`timescale 1ns / 1ps
module cdc_queue import cdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_data
);
   localparam int PtrBits = $clog2(QueueDepth);
   cmd_type             mem_ff [QueueDepth];
   logic [PtrBits-1:0]  wr_ff, rd_ff;
   logic [PtrBits:0]    cnt_ff;
   logic                push, pop;

   assign in_ready  = (cnt_ff != (PtrBits+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
      end
   end
endmodule

[rtl/core/cdc_back.sv]
// back end: sorted insertion, run merge walk and result emission
// depends on cdc_pkg
`timescale 1ns / 1ps
module cdc_back import cdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_SHIFT, ST_LOAD, ST_MERGE, ST_EMIT_RD, ST_EMIT, ST_CLEAR
   } state_type;

   // sorted store; entries shifted up one per cycle during insertion
   logic [OffsetBits-1:0] src_mem [MaxBlocks];
   logic [OffsetBits-1:0] dst_mem [MaxBlocks];
   logic [LenBits-1:0]    len_mem [MaxBlocks];

   state_type             state_ff;
   logic [CntBits-1:0]    fill_ff;
   logic [CntBits-1:0]    pos_ff;
   logic                  last_ff;
   cmd_type               new_ff;
   logic [IdxBits-1:0]    head_ff;
   logic [CntBits-1:0]    cur_ff;
   logic [OffsetBits-1:0] hsrc_ff, hdst_ff;
   logic [LenBits-1:0]    hlen_ff;
   logic [LenBits-1:0]    min_ff, max_ff, tot_ff;
   logic [CntBits-1:0]    runs_ff;
   logic [CntBits-1:0]    emit_ff;
   rsp_type               out_ff;
   logic                  out_valid_ff;
   logic [OffsetBits-1:0] rd_src_ff, rd_dst_ff;
   logic [LenBits-1:0]    rd_len_ff;

   logic [IdxBits-1:0]    raddr, cidx, eidx;
   logic [LenBits-1:0]    fin_len, nmin, nmax, ntot;
   logic                  cont;
   logic [LenBits-1:0]    dsrc, ddst;

   assign cidx = cur_ff[IdxBits-1:0];
   assign eidx = emit_ff[IdxBits-1:0];
   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // read address: the entry needed in the following cycle
   always_comb begin
      unique case (state_ff)
         ST_IDLE:    raddr = IdxBits'(fill_ff - 1'b1);
         ST_SHIFT:   raddr = IdxBits'(pos_ff - 2'd2);
         ST_MERGE:   raddr = IdxBits'(cur_ff + 1'b1);
         ST_EMIT_RD: raddr = eidx;
         ST_EMIT:    raddr = eidx;
         default:    raddr = '0;
      endcase
   end

   // registered read port of the store
   always_ff @(posedge clock) begin
      rd_src_ff <= src_mem[raddr];
      rd_dst_ff <= dst_mem[raddr];
      rd_len_ff <= len_mem[raddr];
   end

   // continuity of current entry against run head
   assign dsrc = LenBits'(rd_src_ff) - LenBits'(hsrc_ff);
   assign ddst = LenBits'(rd_dst_ff) - LenBits'(hdst_ff);
   assign cont = (rd_src_ff >= hsrc_ff) && (dsrc == hlen_ff) &&
                 (rd_dst_ff >= hdst_ff) && (ddst == hlen_ff);
   assign fin_len = hlen_ff;
   assign nmin = (fin_len < min_ff) ? fin_len : min_ff;
   assign nmax = (fin_len > max_ff) ? fin_len : max_ff;
   assign ntot = tot_ff + fin_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         out_valid_ff <= 1'b0;
         min_ff <= '1; max_ff <= '0; tot_ff <= '0; runs_ff <= '0;
      end else begin
         if (out_valid_ff && rsp_ready && state_ff != ST_EMIT) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  new_ff  <= cmd_data;
                  last_ff <= cmd_data.last;
                  pos_ff  <= fill_ff;
                  if (cmd_data.store) state_ff <= ST_SHIFT;
                  else if (cmd_data.last) begin
                     state_ff <= (fill_ff == '0) ? ST_IDLE : ST_LOAD;
                  end
               end
            end
            // one entry moves up per cycle until the slot is found
            ST_SHIFT: begin
               if (pos_ff != '0 && rd_src_ff > new_ff.src) begin
                  src_mem[pos_ff[IdxBits-1:0]] <= rd_src_ff;
                  dst_mem[pos_ff[IdxBits-1:0]] <= rd_dst_ff;
                  len_mem[pos_ff[IdxBits-1:0]] <= rd_len_ff;
                  pos_ff <= pos_ff - 1'b1;
               end else begin
                  src_mem[pos_ff[IdxBits-1:0]] <= new_ff.src;
                  dst_mem[pos_ff[IdxBits-1:0]] <= new_ff.dst;
                  len_mem[pos_ff[IdxBits-1:0]] <= LenBits'(new_ff.len);
                  fill_ff <= fill_ff + 1'b1;
                  state_ff <= last_ff ? ST_LOAD : ST_IDLE;
               end
            end
            // read the first entry as the initial run head
            ST_LOAD: begin
               cur_ff <= '0;
               state_ff <= ST_MERGE;
            end
            // walk sorted entries, folding continuations into the head
            ST_MERGE: begin
               if (cur_ff == '0) begin
                  head_ff <= '0;
                  hsrc_ff <= rd_src_ff;
                  hdst_ff <= rd_dst_ff;
                  hlen_ff <= rd_len_ff;
                  cur_ff <= cur_ff + 1'b1;
               end else if (cur_ff == fill_ff) begin
                  len_mem[head_ff] <= fin_len;
                  min_ff <= nmin; max_ff <= nmax; tot_ff <= ntot;
                  runs_ff <= runs_ff + 1'b1;
                  emit_ff <= '0;
                  state_ff <= ST_EMIT_RD;
               end else if (cont) begin
                  hlen_ff <= hlen_ff + rd_len_ff;
                  len_mem[cidx] <= '0;
                  cur_ff <= cur_ff + 1'b1;
               end else begin
                  len_mem[head_ff] <= fin_len;
                  min_ff <= nmin; max_ff <= nmax; tot_ff <= ntot;
                  runs_ff <= runs_ff + 1'b1;
                  head_ff <= cidx;
                  hsrc_ff <= rd_src_ff;
                  hdst_ff <= rd_dst_ff;
                  hlen_ff <= rd_len_ff;
                  cur_ff <= cur_ff + 1'b1;
               end
            end
            // read the entry of the next result beat
            ST_EMIT_RD: begin
               state_ff <= ST_EMIT;
            end
            // load one result into the output register when free
            ST_EMIT: begin
               if (!out_valid_ff || rsp_ready) begin
                  out_ff.out_src    <= rd_src_ff;
                  out_ff.out_dst    <= rd_dst_ff;
                  out_ff.out_length <= rd_len_ff;
                  out_valid_ff <= 1'b1;
                  if (emit_ff + 1'b1 == fill_ff) begin
                     out_ff.min_run <= min_ff;
                     out_ff.max_run <= max_ff;
                     out_ff.total_bytes <= tot_ff;
                     out_ff.run_count <= runs_ff;
                     out_ff.final_entry <= 1'b1;
                     state_ff <= ST_CLEAR;
                  end else begin
                     out_ff.min_run <= '0;
                     out_ff.max_run <= '0;
                     out_ff.total_bytes <= '0;
                     out_ff.run_count <= '0;
                     out_ff.final_entry <= 1'b0;
                     state_ff <= ST_EMIT_RD;
                  end
                  emit_ff <= emit_ff + 1'b1;
               end
            end
            // batch done: clear batch state
            ST_CLEAR: begin
               fill_ff <= '0;
               min_ff <= '1; max_ff <= '0; tot_ff <= '0; runs_ff <= '0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[rtl/core/copy_descriptor_coalescer_top.sv]
// top level of the copy descriptor coalescer
// depends on cdc_pkg, cdc_front, cdc_queue, cdc_back
//
// channel   dir  handshake             payload
// req       in   req_valid/req_ready   req_data (req_type)
// rsp       out  rsp_valid/rsp_ready   rsp_data (rsp_type)
//
// a stored descriptor is taken in idle, then the shift state moves it past the entries
// it passes during sorted insertion (one store shift per cycle); a closing descriptor adds
// a load state to read the first entry, then the merge walk, and emission does a store
// read, then a load, per result beat; a clear state then clears the batch;
// reset is synchronous and clears fill count and accumulators; rsp stalls hold the
// back end during emit, and the two-entry queue then stalls req
`timescale 1ns / 1ps
module copy_descriptor_coalescer_top import cdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic    f_valid, f_ready, b_valid, b_ready;
   cmd_type f_data, b_data;

   cdc_front u_front (.clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data));
   cdc_queue u_queue (.clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_data(f_data), .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data));
   cdc_back u_back (.clock, .reset, .cmd_valid(b_valid), .cmd_ready(b_ready),
      .cmd_data(b_data), .rsp_valid, .rsp_ready, .rsp_data);
endmodule

[rtl/core/cdc_checker.sv]
// port checker for the copy descriptor coalescer
// depends on cdc_pkg; bound to copy_descriptor_coalescer_top
`timescale 1ns / 1ps
module cdc_port_check import cdc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");
   // statistics only on the final beat
   a_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.final_entry |-> rsp_data.run_count == '0)
      else $error("stats on non-final beat");
   // final beat has at least one run
   a_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_entry |-> rsp_data.run_count != '0)
      else $error("final beat with no runs");
   // min never above max on final beat
   a_minmax: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_entry |-> rsp_data.min_run <= rsp_data.max_run)
      else $error("min above max");
endmodule

bind copy_descriptor_coalescer_top cdc_port_check u_port_check (.clock, .reset,
   .rsp_valid, .rsp_ready, .rsp_data);

[tb/cdc_checker.sv]
// checker for the copy descriptor coalescer: watches both channels,
// predicts the sorted and merged result beats, compares them; uses cdc_pkg
`timescale 1ns / 1ps
module cdc_checker import cdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      batch_count,
   output int      beat_count
);
   // predictor state: sorted descriptor store and fill level
   logic [OffsetBits-1:0] sorted_src [MaxBlocks];
   logic [OffsetBits-1:0] sorted_dst [MaxBlocks];
   logic [LenBits-1:0]    sorted_len [MaxBlocks];
   int                    held;
   rsp_type               expected_beats [$];

   // stable insertion of one descriptor
   task automatic insert_descriptor(input req_type d);
      int pos;
      pos = held;
      while (pos > 0 && sorted_src[pos-1] > d.src_addr) begin
         sorted_src[pos] = sorted_src[pos-1];
         sorted_dst[pos] = sorted_dst[pos-1];
         sorted_len[pos] = sorted_len[pos-1];
         pos--;
      end
      sorted_src[pos] = d.src_addr;
      sorted_dst[pos] = d.dst_addr;
      sorted_len[pos] = LenBits'(d.length);
      held++;
   endtask

   // merge runs and queue one beat per stored entry
   task automatic coalesce_batch();
      int                 head, runs;
      logic [LenBits-1:0] lo, hi, sum, hl;
      logic [OffsetBits:0] ds, dd;
      rsp_type            r;
      head = 0; runs = 0; lo = '1; hi = '0; sum = '0;
      for (int i = 1; i < held; i++) begin
         hl = sorted_len[head];
         ds = {1'b0, sorted_src[i]} - {1'b0, sorted_src[head]};
         dd = {1'b0, sorted_dst[i]} - {1'b0, sorted_dst[head]};
         if (sorted_src[i] >= sorted_src[head] && sorted_dst[i] >= sorted_dst[head] &&
             LenBits'(ds) == hl && LenBits'(dd) == hl) begin
            sorted_len[head] = hl + sorted_len[i];
            sorted_len[i] = '0;
         end else begin
            if (hl < lo) lo = hl;
            if (hl > hi) hi = hl;
            sum = sum + hl; runs++;
            head = i;
         end
      end
      if (held > 0) begin
         hl = sorted_len[head];
         if (hl < lo) lo = hl;
         if (hl > hi) hi = hl;
         sum = sum + hl; runs++;
      end
      for (int i = 0; i < held; i++) begin
         r = '0;
         r.out_src = sorted_src[i];
         r.out_dst = sorted_dst[i];
         r.out_length = sorted_len[i];
         if (i + 1 == held) begin
            r.min_run = lo; r.max_run = hi; r.total_bytes = sum;
            r.run_count = CntBits'(runs); r.final_entry = 1'b1;
         end
         expected_beats.push_back(r);
      end
      held = 0;
   endtask

   assign pending_count = expected_beats.size();

   // sample both channels at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held <= 0;
         fail_count <= 0;
         batch_count <= 0;
         beat_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (held < MaxBlocks) insert_descriptor(req_data);
            if (req_data.last_block) begin
               coalesce_batch();
               batch_count <= batch_count + 1;
            end
         end
         if (rsp_valid && rsp_ready) begin
            beat_count <= beat_count + 1;
            if (expected_beats.size() == 0) begin
               if (fail_count < 10) $display("unexpected beat %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data !== want) begin
                  if (fail_count < 10)
                     $display("beat mismatch\n  want %p\n  got  %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[tb/tb_copy_descriptor_coalescer_top.sv]
// testbench top for the copy descriptor coalescer: drives descriptor batches,
// throttles the result side, gives the verdict; uses cdc_pkg, cdc_checker
`timescale 1ns / 1ps
module tb_copy_descriptor_coalescer_top;
   import cdc_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending_count, batch_count, beat_count;
   bit      calm = 1'b0;
   int      hold_off = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   copy_descriptor_coalescer_top u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   cdc_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .fail_count, .pending_count, .batch_count, .beat_count
   );

   // receiver throttle with an optional long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   function automatic logic [OffsetBits-1:0] rand_wide();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return OffsetBits'($urandom_range(255));
         default: return OffsetBits'({$urandom, $urandom});
      endcase
   endfunction

   // offer one descriptor beat and wait for it to be taken; valid stays up
   // after acceptance so back-to-back beats need no gap
   task automatic send_descriptor(input logic [OffsetBits-1:0] s, d, l, input logic fin);
      while (!calm && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= '{src_addr: s, dst_addr: d, length: l, last_block: fin};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // batch of mostly contiguous pieces, shuffled, with some breaks
   task automatic send_batch(input int n);
      logic [OffsetBits-1:0] s, d, l, ps [$], pd [$], pl [$];
      int                    k;
      s = rand_wide(); d = rand_wide();
      for (int i = 0; i < n; i++) begin
         l = ($urandom_range(9) == 0) ? rand_wide() : OffsetBits'($urandom_range(64));
         ps.push_back(s); pd.push_back(d); pl.push_back(l);
         if ($urandom_range(4) == 0) begin
            s = rand_wide(); d = rand_wide();
         end else begin
            s = s + l;
            d = ($urandom_range(7) == 0) ? d + l + 1'b1 : d + l;
         end
      end
      while (ps.size() > 0) begin
         k = ($urandom_range(2) == 0) ? $urandom_range(ps.size() - 1) : 0;
         send_descriptor(ps[k], pd[k], pl[k], ps.size() == 1);
         ps.delete(k); pd.delete(k); pl.delete(k);
      end
   endtask

   initial begin
      int sent;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: lone extremes, equal sources, full wrap-free maxima
      send_descriptor('0, '0, '0, 1'b1);
      send_descriptor('1, '1, '1, 1'b1);
      send_descriptor(48'd100, 48'd5, 48'd10, 1'b0);
      send_descriptor(48'd100, 48'd9, 48'd3, 1'b0);
      send_descriptor(48'd50, 48'd0, 48'd50, 1'b0);
      send_descriptor(48'd150, 48'd60, 48'd0, 1'b1);
      send_descriptor(48'd0, 48'd0, '1, 1'b0);
      send_descriptor('1, '1, '1, 1'b0);
      send_descriptor(48'd10, '1, 48'd4, 1'b0);
      send_descriptor(48'd14, 48'd3, 48'd4, 1'b1);
      sent = 10;

      // full store with overflow drops, closed by a dropped last descriptor
      calm = 1'b1;
      for (int i = 0; i < 70; i++)
         send_descriptor(OffsetBits'((69 - i) * 8), OffsetBits'((69 - i) * 8),
                         48'd8, i == 69);
      sent += 70;

      // receiver holds off while the next batch piles up behind the full one
      hold_off = 400;
      send_batch(6);
      sent += 6;
      calm = 1'b0;

      // random batches, quiet stretch in the middle
      while (sent < 470) begin
         int n;
         calm = (sent > 200 && sent < 300);
         n = ($urandom_range(15) == 0) ? $urandom_range(64, 40) : $urandom_range(1, 8);
         if ($urandom_range(9) == 0) begin
            send_descriptor(rand_wide(), rand_wide(), rand_wide(), 1'b1);
            sent += 1;
         end else begin
            send_batch(n);
            sent += n;
         end
      end
      req_valid <= 1'b0;

      wait (pending_count == 0);
      repeat (300) @(posedge clock);
      $display("covered %0d batches and %0d result beats, including a full store",
               batch_count, beat_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end
endmodule

[filelist.f]
rtl/core/cdc_pkg.sv
rtl/core/cdc_front.sv
rtl/core/cdc_queue.sv
rtl/core/cdc_back.sv
rtl/core/copy_descriptor_coalescer_top.sv
rtl/core/cdc_checker.sv
tb/cdc_checker.sv
tb/tb_copy_descriptor_coalescer_top.sv
